// ----- rtl/ubx_frame_receiver_assert.svh -----
// Assertion macros for the frame receiver RTL.
`ifndef UBX_FRAME_RECEIVER_ASSERT_SVH
`define UBX_FRAME_RECEIVER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define UBX_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define UBX_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define UBX_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define UBX_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ----- rtl/ubx_fr_pkg.sv -----
// Shared constants and types of the frame receiver.
package ubx_fr_pkg;

  localparam int POS_PAYLOAD_BYTES = 92;
  localparam int INDEX_W           = 10;
  localparam int CFG_INDEX_W       = 2;

  localparam logic [7:0] SYNC_CHAR_1 = 8'hB5;
  localparam logic [7:0] SYNC_CHAR_2 = 8'h62;
  localparam logic [7:0] CLASS_NAV   = 8'h01;
  localparam logic [7:0] ID_NAV_PVT  = 8'h07;
  localparam logic [7:0] CLASS_ACK   = 8'h05;
  localparam logic [7:0] ID_ACK_ACK  = 8'h01;
  localparam logic [7:0] ID_ACK_NAK  = 8'h00;

  localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
  localparam logic [1:0] KIND_FRAME_END = 2'd1;
  localparam logic [1:0] KIND_ACK       = 2'd2;
  localparam logic [1:0] KIND_NAK       = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] CFG_CHECK_ENABLE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACK_CLASS    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACK_MSG_ID   = 2'd2;

  typedef struct packed {
    logic       check_enable;
    logic [7:0] ack_class;
    logic [7:0] ack_msg_id;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic [1:0]         kind;
    logic [7:0]         data;
    logic [INDEX_W-1:0] index;
    logic               ok;
  } result_t;

endpackage

// ----- rtl/ubx_fr_parser.sv -----
// Frame parse state machine: decodes one word per step and updates the checksums.
module ubx_fr_parser import ubx_fr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output result_t    res
);

  typedef enum logic [3:0] {
    PH_HUNT    = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LENLO   = 4'd4,
    PH_LENHI   = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_ACKCLS  = 4'd7,
    PH_ACKID   = 4'd8,
    PH_CKA     = 4'd9,
    PH_CKB     = 4'd10
  } phase_t;

  phase_t             phase, phase_next;
  logic               frame_is_ack, frame_is_ack_next;
  logic               ack_polarity, ack_polarity_next;
  logic [7:0]         length_low, length_low_next;
  logic [INDEX_W-1:0] payload_count, payload_count_next;
  logic [7:0]         sum_a, sum_a_next;
  logic [7:0]         sum_b, sum_b_next;
  logic [7:0]         received_ck_a, received_ck_a_next;

  logic [7:0]   base_a, base_b, add_a, add_b;
  logic [15:0]  frame_len;
  logic [INDEX_W:0] count_inc;

  assign base_a    = (phase == PH_CLASS) ? 8'd0 : sum_a;
  assign base_b    = (phase == PH_CLASS) ? 8'd0 : sum_b;
  assign add_a     = base_a + rx_byte;
  assign add_b     = base_b + add_a;
  assign frame_len = {rx_byte, length_low};
  assign count_inc = {1'b0, payload_count} + {{INDEX_W{1'b0}}, 1'b1};

  always_comb begin
    phase_next         = phase;
    frame_is_ack_next  = frame_is_ack;
    ack_polarity_next  = ack_polarity;
    length_low_next    = length_low;
    payload_count_next = payload_count;
    sum_a_next         = sum_a;
    sum_b_next         = sum_b;
    received_ck_a_next = received_ck_a;
    res                = '0;
    unique case (phase)
      PH_SYNC2: begin
        if (rx_byte == SYNC_CHAR_2) begin
          phase_next = PH_CLASS;
        end else if (rx_byte != SYNC_CHAR_1) begin
          phase_next = PH_HUNT;
        end
      end
      PH_CLASS: begin
        sum_a_next = add_a;
        sum_b_next = add_b;
        if (rx_byte == CLASS_NAV) begin
          frame_is_ack_next = 1'b0;
          phase_next        = PH_ID;
        end else if (rx_byte == CLASS_ACK) begin
          frame_is_ack_next = 1'b1;
          phase_next        = PH_ID;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_ID: begin
        sum_a_next = add_a;
        sum_b_next = add_b;
        phase_next = PH_LENLO;
        if (frame_is_ack) begin
          if (rx_byte == ID_ACK_ACK) begin
            ack_polarity_next = 1'b1;
          end else if (rx_byte == ID_ACK_NAK) begin
            ack_polarity_next = 1'b0;
          end else begin
            phase_next = PH_HUNT;
          end
        end else if (rx_byte != ID_NAV_PVT) begin
          phase_next = PH_HUNT;
        end
      end
      PH_LENLO: begin
        sum_a_next      = add_a;
        sum_b_next      = add_b;
        length_low_next = rx_byte;
        phase_next      = PH_LENHI;
      end
      PH_LENHI: begin
        sum_a_next         = add_a;
        sum_b_next         = add_b;
        payload_count_next = '0;
        if (frame_is_ack) begin
          phase_next = PH_ACKCLS;
        end else if (frame_len == 16'(POS_PAYLOAD_BYTES)) begin
          phase_next = PH_PAYLOAD;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_PAYLOAD: begin
        sum_a_next         = add_a;
        sum_b_next         = add_b;
        res.valid          = 1'b1;
        res.kind           = KIND_PAYLOAD;
        res.data           = rx_byte;
        res.index          = payload_count;
        payload_count_next = count_inc[INDEX_W-1:0];
        if (count_inc >= (INDEX_W+1)'(POS_PAYLOAD_BYTES)) begin
          phase_next = PH_CKA;
        end
      end
      PH_ACKCLS: begin
        sum_a_next = add_a;
        sum_b_next = add_b;
        phase_next = (rx_byte == cfg.ack_class) ? PH_ACKID : PH_HUNT;
      end
      PH_ACKID: begin
        sum_a_next = add_a;
        sum_b_next = add_b;
        if (rx_byte == cfg.ack_msg_id) begin
          res.valid = 1'b1;
          res.kind  = ack_polarity ? KIND_ACK : KIND_NAK;
        end
        phase_next = PH_HUNT;
      end
      PH_CKA: begin
        received_ck_a_next = rx_byte;
        phase_next         = PH_CKB;
      end
      PH_CKB: begin
        res.valid  = 1'b1;
        res.kind   = KIND_FRAME_END;
        res.ok     = !(cfg.check_enable && ((received_ck_a != sum_a) || (rx_byte != sum_b)));
        phase_next = PH_HUNT;
      end
      default: begin
        phase_next = (rx_byte == SYNC_CHAR_1) ? PH_SYNC2 : PH_HUNT;
      end
    endcase
    if (!step) begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      frame_is_ack  <= 1'b0;
      ack_polarity  <= 1'b0;
      length_low    <= '0;
      payload_count <= '0;
      sum_a         <= '0;
      sum_b         <= '0;
      received_ck_a <= '0;
    end else if (step) begin
      phase         <= phase_next;
      frame_is_ack  <= frame_is_ack_next;
      ack_polarity  <= ack_polarity_next;
      length_low    <= length_low_next;
      payload_count <= payload_count_next;
      sum_a         <= sum_a_next;
      sum_b         <= sum_b_next;
      received_ck_a <= received_ck_a_next;
    end
  end

endmodule

// ----- rtl/ubx_frame_receiver.sv -----
// Top level of the UBX frame receiver: word handshakes, configuration and result register.
// Takes one received byte per cycle with no bubbles, sustained as long as results are taken;
// a byte's result (if any) is presented from the result register once the byte advances out of
// the input word register, which waits while a result is still held. The rate is set by the
// single-pass decode between the input word register and the result register. Position
// frames of class 0x01 id 0x07 with the fixed payload length yield one result per payload
// byte and a frame-end result with the checksum verdict; acknowledge frames for the
// configured class and id yield one ACK or NAK result. Everything else yields nothing.
`include "ubx_frame_receiver_assert.svh"

module ubx_frame_receiver import ubx_fr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   rx_valid,
  output logic                   rx_ready,
  input  logic [7:0]             rx_byte,
  output logic                   result_valid,
  input  logic                   result_ready,
  output logic [1:0]             result_kind,
  output logic [7:0]             payload_byte,
  output logic [INDEX_W-1:0]     byte_index,
  output logic                   frame_ok,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]             cfg_data
);

  cfg_t       cfg;
  result_t    res;
  logic       word_valid;
  logic [7:0] word_byte;
  logic       advance;

  assign advance  = word_valid && (!result_valid || result_ready);
  assign rx_ready = !word_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.check_enable <= 1'b1;
      cfg.ack_class    <= 8'd6;
      cfg.ack_msg_id   <= 8'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHECK_ENABLE: cfg.check_enable <= cfg_data[0];
        CFG_ACK_CLASS:    cfg.ack_class    <= cfg_data;
        CFG_ACK_MSG_ID:   cfg.ack_msg_id   <= cfg_data;
        default:          cfg              <= cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (rx_ready) begin
        word_valid <= rx_valid;
      end
      if (advance) begin
        result_valid <= res.valid;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && rx_ready) begin
      word_byte <= rx_byte;
    end
    if (advance && res.valid) begin
      result_kind  <= res.kind;
      payload_byte <= res.data;
      byte_index   <= res.index;
      frame_ok     <= res.ok;
    end
  end

  ubx_fr_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (word_byte),
    .cfg     (cfg),
    .res     (res)
  );

  `UBX_ASSERT_SAME(a_index_in_range, clk, rst, result_valid && (result_kind == KIND_PAYLOAD), byte_index < INDEX_W'(POS_PAYLOAD_BYTES), "payload index beyond frame length")
  `UBX_ASSERT_SAME(a_clean_fields, clk, rst, result_valid && (result_kind != KIND_PAYLOAD), (payload_byte == 8'd0) && (byte_index == '0), "non-payload result carries data")
  `UBX_ASSERT_SAME(a_ok_only_at_end, clk, rst, result_valid && (result_kind != KIND_FRAME_END), !frame_ok, "ok flag outside frame end")
  `UBX_ASSERT_NEXT(a_word_taken, clk, rst, word_valid && !result_valid, !word_valid || $past(rx_valid), "held word not consumed")

endmodule

// ----- tb/sv/ubx_frame_checker.sv -----
// Frame receiver checker: tracks the parser state, predicts each result word and compares.
module ubx_frame_checker import ubx_fr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   rx_valid,
  input  logic                   rx_ready,
  input  logic [7:0]             rx_byte,
  input  logic                   result_valid,
  input  logic                   result_ready,
  input  logic [1:0]             result_kind,
  input  logic [7:0]             payload_byte,
  input  logic [INDEX_W-1:0]     byte_index,
  input  logic                   frame_ok,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]             cfg_data,
  output int                     errors,
  output int                     outstanding
);

  typedef enum logic [3:0] {
    ST_HUNT, ST_SYNC_2, ST_CLASS, ST_MSG_ID, ST_LEN_LO, ST_LEN_HI,
    ST_PAYLOAD, ST_ACK_CLASS, ST_ACK_ID, ST_CK_A, ST_CK_B
  } parser_state_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         data;
    logic [INDEX_W-1:0] index;
    logic               ok;
  } frame_result_t;

  parser_state_t      phase;
  logic               is_ack;
  logic               is_positive;
  logic [7:0]         len_lo;
  logic [INDEX_W-1:0] pay_idx;
  logic [7:0]         fl_a;
  logic [7:0]         fl_b;
  logic [7:0]         ck_a_rx;
  logic               chk_en;
  logic [7:0]         want_class;
  logic [7:0]         want_id;

  frame_result_t pending_results[$];
  frame_result_t oldest;
  int            mismatches = 0;

  assign errors = mismatches;

  function automatic void fletcher_add(input logic [7:0] b);
    fl_a = fl_a + b;
    fl_b = fl_b + fl_a;
  endfunction

  function automatic void push_result(input logic [1:0] kind, input logic [7:0] data,
                                      input logic [INDEX_W-1:0] index, input logic ok);
    frame_result_t r;
    r.kind  = kind;
    r.data  = data;
    r.index = index;
    r.ok    = ok;
    pending_results.push_back(r);
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    case (phase)
      ST_SYNC_2: begin
        if (b == SYNC_CHAR_2) phase = ST_CLASS;
        else if (b != SYNC_CHAR_1) phase = ST_HUNT;
      end
      ST_CLASS: begin
        fl_a = '0;
        fl_b = '0;
        fletcher_add(b);
        if (b == CLASS_NAV) begin
          is_ack = 1'b0;
          phase  = ST_MSG_ID;
        end else if (b == CLASS_ACK) begin
          is_ack = 1'b1;
          phase  = ST_MSG_ID;
        end else begin
          phase = ST_HUNT;
        end
      end
      ST_MSG_ID: begin
        fletcher_add(b);
        phase = ST_LEN_LO;
        if (is_ack) begin
          if (b == ID_ACK_ACK) is_positive = 1'b1;
          else if (b == ID_ACK_NAK) is_positive = 1'b0;
          else phase = ST_HUNT;
        end else if (b != ID_NAV_PVT) begin
          phase = ST_HUNT;
        end
      end
      ST_LEN_LO: begin
        fletcher_add(b);
        len_lo = b;
        phase  = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        fletcher_add(b);
        pay_idx = '0;
        if (is_ack) phase = ST_ACK_CLASS;
        else if ({b, len_lo} == 16'(POS_PAYLOAD_BYTES)) phase = ST_PAYLOAD;
        else phase = ST_HUNT;
      end
      ST_PAYLOAD: begin
        fletcher_add(b);
        push_result(KIND_PAYLOAD, b, pay_idx, 1'b0);
        if (int'(pay_idx) + 1 >= POS_PAYLOAD_BYTES) phase = ST_CK_A;
        pay_idx = pay_idx + 1'b1;
      end
      ST_ACK_CLASS: begin
        fletcher_add(b);
        phase = (b == want_class) ? ST_ACK_ID : ST_HUNT;
      end
      ST_ACK_ID: begin
        fletcher_add(b);
        if (b == want_id) push_result(is_positive ? KIND_ACK : KIND_NAK, 8'd0, '0, 1'b0);
        phase = ST_HUNT;
      end
      ST_CK_A: begin
        ck_a_rx = b;
        phase   = ST_CK_B;
      end
      ST_CK_B: begin
        push_result(KIND_FRAME_END, 8'd0, '0, !(chk_en && (ck_a_rx != fl_a || b != fl_b)));
        phase = ST_HUNT;
      end
      default: begin
        phase = (b == SYNC_CHAR_1) ? ST_SYNC_2 : ST_HUNT;
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      phase       = ST_HUNT;
      is_ack      = 1'b0;
      is_positive = 1'b0;
      len_lo      = '0;
      pay_idx     = '0;
      fl_a        = '0;
      fl_b        = '0;
      ck_a_rx     = '0;
      chk_en      = 1'b1;
      want_class  = 8'd6;
      want_id     = 8'd8;
      pending_results.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result expected none, got kind %0d data %0d index %0d ok %0d",
                   $time, result_kind, payload_byte, byte_index, frame_ok);
          mismatches++;
        end else begin
          oldest = pending_results.pop_front();
          check_field("result_kind", oldest.kind, result_kind);
          check_field("payload_byte", oldest.data, payload_byte);
          check_field("byte_index", oldest.index, byte_index);
          check_field("frame_ok", oldest.ok, frame_ok);
        end
      end
      if (rx_valid && rx_ready) parse_byte(rx_byte);
      if (cfg_we) begin
        case (cfg_index)
          CFG_CHECK_ENABLE: chk_en     = cfg_data[0];
          CFG_ACK_CLASS:    want_class = cfg_data;
          CFG_ACK_MSG_ID:   want_id    = cfg_data;
          default: ;
        endcase
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

// ----- tb/sv/tb_ubx_frame_receiver.sv -----
// Frame receiver testbench top: clock, reset, byte stream and register stimulus, verdict.
module tb_ubx_frame_receiver;
  import ubx_fr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_BYTES = 300;

  typedef enum {CK_GOOD, CK_BAD, CK_NONE} ck_mode_t;

  logic                   clk;
  logic                   rst;
  logic                   rx_valid;
  logic                   rx_ready;
  logic [7:0]             rx_byte;
  logic                   result_valid;
  logic                   result_ready;
  logic [1:0]             result_kind;
  logic [7:0]             payload_byte;
  logic [INDEX_W-1:0]     byte_index;
  logic                   frame_ok;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [7:0]             cfg_data;

  int         fail_cnt;
  int         outstanding;
  int         cycle_cnt = 0;
  int         send_pct = 0;
  int         recv_pct = 0;
  int         sent;
  logic [7:0] tgt_class;
  logic [7:0] tgt_id;
  logic [7:0] frame_q[$];

  ubx_frame_receiver DUT (
    .clk          (clk),
    .rst          (rst),
    .rx_valid     (rx_valid),
    .rx_ready     (rx_ready),
    .rx_byte      (rx_byte),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_kind  (result_kind),
    .payload_byte (payload_byte),
    .byte_index   (byte_index),
    .frame_ok     (frame_ok),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  ubx_frame_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .rx_valid     (rx_valid),
    .rx_ready     (rx_ready),
    .rx_byte      (rx_byte),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_kind  (result_kind),
    .payload_byte (payload_byte),
    .byte_index   (byte_index),
    .frame_ok     (frame_ok),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .errors       (fail_cnt),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    result_ready <= ($urandom_range(0, 99) < recv_pct) ? 1'b0 : 1'b1;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_frame(input logic [7:0] cls, input logic [7:0] id,
                                    input logic [15:0] len, input logic [7:0] body[$],
                                    input ck_mode_t mode);
    logic [7:0] head[4];
    logic [7:0] fa;
    logic [7:0] fb;
    logic [7:0] b;
    head = '{cls, id, len[7:0], len[15:8]};
    fa = '0;
    fb = '0;
    frame_q.push_back(SYNC_CHAR_1);
    frame_q.push_back(SYNC_CHAR_2);
    for (int i = 0; i < body.size() + 4; i++) begin
      b  = (i < 4) ? head[i] : body[i-4];
      fa = fa + b;
      fb = fb + fa;
      frame_q.push_back(b);
    end
    if (mode == CK_BAD) begin
      if ($urandom_range(0, 1)) fa = fa ^ (8'd1 << $urandom_range(0, 7));
      else fb = fb ^ (8'd1 << $urandom_range(0, 7));
    end
    if (mode != CK_NONE) begin
      frame_q.push_back(fa);
      frame_q.push_back(fb);
    end
  endfunction

  task automatic send_word(input logic [7:0] b);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_pct) gap++;
    if (gap > 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!rx_ready) @(posedge clk);
    sent++;
  endtask

  task automatic flush_frame();
    while (frame_q.size() > 0) send_word(frame_q.pop_front());
  endtask

  task automatic drain();
    rx_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_config(input logic ce, input logic [7:0] cls, input logic [7:0] id);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CHECK_ENABLE;
    cfg_data  <= {7'd0, ce};
    @(posedge clk);
    cfg_index <= CFG_ACK_CLASS;
    cfg_data  <= cls;
    @(posedge clk);
    cfg_index <= CFG_ACK_MSG_ID;
    cfg_data  <= id;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tgt_class = cls;
    tgt_id    = id;
  endtask

  task automatic random_frame();
    logic [7:0]  body[$];
    logic [7:0]  cls;
    logic [7:0]  id;
    logic [15:0] len;
    int          sel;
    ck_mode_t    mode;
    sel  = $urandom_range(0, 99);
    mode = ($urandom_range(0, 4) == 0) ? CK_BAD : CK_GOOD;
    if ($urandom_range(0, 7) == 0) frame_q.push_back(SYNC_CHAR_1);
    if (sel < 35) begin
      repeat (POS_PAYLOAD_BYTES) body.push_back(rand_byte());
      add_frame(CLASS_NAV, ID_NAV_PVT, 16'(POS_PAYLOAD_BYTES), body, mode);
    end else if (sel < 60) begin
      body.push_back(tgt_class);
      body.push_back(tgt_id);
      repeat ($urandom_range(0, 3)) body.push_back(rand_byte());
      case ($urandom_range(0, 2))
        0:       len = 16'd2;
        1:       len = 16'(body.size());
        default: len = 16'($urandom_range(0, 65535));
      endcase
      add_frame(CLASS_ACK, $urandom_range(0, 1) ? ID_ACK_ACK : ID_ACK_NAK, len, body, mode);
    end else if (sel < 70) begin
      cls = tgt_class;
      id  = tgt_id;
      if ($urandom_range(0, 1)) cls = cls + 8'($urandom_range(1, 255));
      else id = id + 8'($urandom_range(1, 255));
      body.push_back(cls);
      body.push_back(id);
      add_frame(CLASS_ACK, $urandom_range(0, 1) ? ID_ACK_ACK : ID_ACK_NAK, 16'd2, body, mode);
    end else if (sel < 85) begin
      case ($urandom_range(0, 4))
        0: begin
          do cls = rand_byte(); while (cls == CLASS_NAV || cls == CLASS_ACK);
          add_frame(cls, rand_byte(), 16'(POS_PAYLOAD_BYTES), body, CK_NONE);
        end
        1: begin
          do id = rand_byte(); while (id == ID_NAV_PVT);
          add_frame(CLASS_NAV, id, 16'(POS_PAYLOAD_BYTES), body, CK_NONE);
        end
        2: begin
          do id = rand_byte(); while (id == ID_ACK_ACK || id == ID_ACK_NAK);
          add_frame(CLASS_ACK, id, 16'd2, body, CK_NONE);
        end
        3: begin
          case ($urandom_range(0, 4))
            0:       len = 16'd0;
            1:       len = 16'(POS_PAYLOAD_BYTES - 1);
            2:       len = 16'(POS_PAYLOAD_BYTES + 1);
            3:       len = 16'(POS_PAYLOAD_BYTES + 256);
            default: len = 16'($urandom_range(0, 65535));
          endcase
          if (len == 16'(POS_PAYLOAD_BYTES)) len = 16'hFFFF;
          repeat ($urandom_range(0, 8)) body.push_back(rand_byte());
          add_frame(CLASS_NAV, ID_NAV_PVT, len, body, mode);
        end
        default: begin
          repeat ($urandom_range(1, 40)) body.push_back(rand_byte());
          add_frame(CLASS_NAV, ID_NAV_PVT, 16'(POS_PAYLOAD_BYTES), body, CK_NONE);
        end
      endcase
    end else begin
      repeat ($urandom_range(1, 12))
        frame_q.push_back(($urandom_range(0, 3) == 0) ? SYNC_CHAR_1 : rand_byte());
    end
  endtask

  initial begin
    rst          = 1'b1;
    rx_valid     = 1'b0;
    rx_byte      = '0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_CHECK_ENABLE;
    cfg_data     = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < 4; p++) begin
      if (p > 0) drain();
      case (p)
        0: begin
          write_config(1'b1, 8'd6, 8'd8);
          send_pct = 0;
          recv_pct = 0;
        end
        1: begin
          write_config(1'b0, 8'h00, 8'hFF);
          send_pct = 85;
          recv_pct = 0;
        end
        2: begin
          write_config(1'b1, 8'hFF, 8'h00);
          send_pct = 0;
          recv_pct = 85;
        end
        default: begin
          write_config(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
          send_pct = 21;
          recv_pct = 21;
        end
      endcase
      if (p == 0) begin
        frame_q.push_back(SYNC_CHAR_1);
        add_frame(CLASS_ACK, ID_ACK_ACK, 16'd2, '{tgt_class, tgt_id}, CK_GOOD);
        add_frame(CLASS_ACK, ID_ACK_NAK, 16'd0, '{tgt_class, tgt_id}, CK_NONE);
        frame_q.push_back(SYNC_CHAR_1);
        frame_q.push_back(SYNC_CHAR_2);
        frame_q.push_back(8'h02);
        flush_frame();
      end
      sent = 0;
      while (sent < PHASE_BYTES) begin
        random_frame();
        flush_frame();
      end
    end
    drain();

    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
